>>> hw/rtl/wpc_pkg.sv
package wpc_pkg;

  localparam int COORD_W    = 8;
  localparam int CELL_W     = 4;
  localparam int DIM_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int LEN_W      = 21;
  localparam int HIT_W      = 11;
  localparam int TOTAL_W    = 23;
  localparam int HIT_WEIGHT = 10;

  localparam int MAP_DIM_DEF             = 256;
  localparam int MAX_WAYPOINTS_DEF       = 16;
  localparam int SAMPLES_PER_SEGMENT_DEF = 100;
  localparam int FRACTION_BITS_DEF       = 8;

  localparam logic [DIM_W-1:0]   DIM_RESET = DIM_W'(200);
  localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
  localparam logic [HIT_W-1:0]   HIT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X    = 3'd0,
    CFG_START_Y    = 3'd1,
    CFG_STOP_X     = 3'd2,
    CFG_STOP_Y     = 3'd3,
    CFG_MAP_WIDTH  = 3'd4,
    CFG_MAP_HEIGHT = 3'd5
  } cfg_idx_t;

endpackage

>>> hw/rtl/wpc_if.sv
interface wpc_in_if;
  import wpc_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [CELL_W-1:0]  cell_value;
  logic               last_waypoint;
  modport source (output valid, mode, point_x, point_y, cell_value, last_waypoint,
                  input ready);
  modport sink   (input valid, mode, point_x, point_y, cell_value, last_waypoint,
                  output ready);
endinterface

interface wpc_out_if;
  import wpc_pkg::*;
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_cost_q8;
  logic [LEN_W-1:0]   path_length_q8;
  logic [HIT_W-1:0]   blocked_samples;
  logic               overflow;
  modport source (output valid, total_cost_q8, path_length_q8, blocked_samples, overflow,
                  input ready);
  modport sink   (input valid, total_cost_q8, path_length_q8, blocked_samples, overflow,
                  output ready);
endinterface

interface wpc_cfg_if;
  import wpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/wpc_ram.sv
module wpc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/waypoint_path_cost_top.sv
// Path cost scorer over a 1-bit occupancy grid held in one MAP_DIM x MAP_DIM
// single-bit RAM. After reset the block clears the grid one entry a cycle and
// takes no item meanwhile; configuration writes are taken at any time. A map-write
// item is written into the grid in the cycle that takes it. A waypoint scores one
// segment: the cycle that takes it, the set-up states ST_DIV and ST_FIX, then the
// run state, in which the grid RAM is read once per sample while the bit-serial
// square root runs alongside, until the last grid read is counted and the root is
// complete, then the accumulate state. The waypoint that closes the path scores a
// second segment to the stop point and then hands over the result from the done
// state. The result sits in an output register, so the next item is taken while
// it waits; a further result holds the scorer, and the input, until that register
// frees.
module waypoint_path_cost_top #(
  parameter int MAP_DIM             = wpc_pkg::MAP_DIM_DEF,
  parameter int MAX_WAYPOINTS       = wpc_pkg::MAX_WAYPOINTS_DEF,
  parameter int SAMPLES_PER_SEGMENT = wpc_pkg::SAMPLES_PER_SEGMENT_DEF,
  parameter int FRACTION_BITS       = wpc_pkg::FRACTION_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  wpc_cfg_if.sink   cfg_ch,
  wpc_in_if.sink    in_ch,
  wpc_out_if.source out_ch
);

  import wpc_pkg::*;

  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int SEG_W   = $clog2(MAX_WAYPOINTS + 1);
  localparam int S       = SAMPLES_PER_SEGMENT;
  localparam int K_W     = $clog2(S + 1);
  localparam int R_W     = $clog2(S);
  localparam int Q_W     = COORD_W + 2;
  localparam int REC_SH  = COORD_W + $clog2(S) + 1;
  localparam int REC_W   = REC_SH + 1;
  localparam int RECIP   = ((1 << REC_SH) + S - 1) / S;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int VW      = SQ_W + 2 * FRACTION_BITS;
  localparam int RT_W    = (VW + 1) / 2;
  localparam int IT_W    = $clog2(RT_W + 1);
  localparam int LS_W    = ((RT_W > LEN_W) ? RT_W : LEN_W) + 1;
  localparam int HT_W    = HIT_W + 4 + FRACTION_BITS;
  localparam int TOT_W   = ((HT_W > LEN_W) ? HT_W : LEN_W) + 1;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_FIX, ST_RUN, ST_ACC, ST_DONE} state_t;

  typedef struct packed {
    logic signed [Q_W-1:0] dq;
    logic [R_W-1:0]        dr;
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] cur;
    logic [R_W-1:0]     rem;
  } pos_t;

  // Floor split of a signed coordinate delta into quotient and remainder by S.
  function automatic step_t split_step(input logic [COORD_W-1:0] dabs,
                                       input logic [COORD_W-1:0] quo,
                                       input logic neg);
    logic [COORD_W:0]   r0;
    logic [COORD_W-1:0] q1;
    logic [R_W-1:0]     r1;
    step_t              st;
    r0 = (COORD_W+1)'(dabs) - (COORD_W+1)'(32'(quo) * 32'(S));
    if (r0 >= (COORD_W+1)'(S)) begin
      q1 = quo + 1'b1;
      r1 = R_W'(r0 - (COORD_W+1)'(S));
    end else begin
      q1 = quo;
      r1 = R_W'(r0);
    end
    if (neg && r1 != '0) begin
      st.dq = -(Q_W'(q1) + Q_W'(1));
      st.dr = R_W'(S) - r1;
    end else if (neg) begin
      st.dq = -Q_W'(q1);
      st.dr = '0;
    end else begin
      st.dq = Q_W'(q1);
      st.dr = r1;
    end
    return st;
  endfunction

  function automatic pos_t advance(input logic [COORD_W-1:0] cur,
                                   input logic [R_W-1:0] rem,
                                   input step_t st);
    logic [R_W:0] rsum;
    logic         carry;
    pos_t         p;
    rsum  = (R_W+1)'(rem) + (R_W+1)'(st.dr);
    carry = (rsum >= (R_W+1)'(S));
    p.rem = carry ? R_W'(rsum - (R_W+1)'(S)) : R_W'(rsum);
    p.cur = COORD_W'(Q_W'(cur) + st.dq + Q_W'(carry));
    return p;
  endfunction

  // configuration
  logic [COORD_W-1:0] start_x_r, start_y_r, stop_x_r, stop_y_r;
  logic [DIM_W-1:0]   map_width_r, map_height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      stop_x_r     <= '0;
      stop_y_r     <= '0;
      map_width_r  <= DIM_RESET;
      map_height_r <= DIM_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_START_X:    start_x_r    <= cfg_ch.data[COORD_W-1:0];
        CFG_START_Y:    start_y_r    <= cfg_ch.data[COORD_W-1:0];
        CFG_STOP_X:     stop_x_r     <= cfg_ch.data[COORD_W-1:0];
        CFG_STOP_Y:     stop_y_r     <= cfg_ch.data[COORD_W-1:0];
        CFG_MAP_WIDTH:  map_width_r  <= cfg_ch.data;
        CFG_MAP_HEIGHT: map_height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // grid clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // datapath registers
  state_t             state_r;
  logic [COORD_W-1:0] prev_x_r, prev_y_r;
  logic [SEG_W-1:0]   seg_cnt_r;
  logic [LEN_W-1:0]   len_sum_r;
  logic [HIT_W-1:0]   hit_sum_r;
  logic               ovf_r;
  logic [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic               second_r, last_r;
  logic [COORD_W-1:0] dabs_x_r, dabs_y_r, quo_x_r, quo_y_r;
  logic               neg_x_r, neg_y_r;
  logic [2*COORD_W-1:0] sqx_r, sqy_r;
  step_t              step_x_r, step_y_r;
  logic [COORD_W-1:0] cur_x_r, cur_y_r;
  logic [R_W-1:0]     rem_x_r, rem_y_r;
  logic [K_W-1:0]     k_r, seg_hits_r;
  logic               rd_pend_r;
  logic [2*RT_W-1:0]  rad_r;
  logic [RT_W-1:0]    root_r;
  logic [RT_W+1:0]    srem_r;
  logic [IT_W-1:0]    it_r;
  logic               out_valid_r, out_ovf_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [HIT_W-1:0]   out_hits_r;

  // combinational helpers
  logic               in_accept, map_wr_ok, samp_ok, out_load, sample_more;
  logic               neg_x, neg_y;
  logic [COORD_W-1:0] dabs_x, dabs_y;
  logic [COORD_W+REC_W-1:0] prod_x, prod_y;
  logic [SQ_W-1:0]    sq_sum;
  pos_t               nx_x, nx_y;
  logic [RT_W+1:0]    sq_shift;
  logic [RT_W+2:0]    sq_trial;
  logic [LS_W-1:0]    len_add;
  logic [HIT_W:0]     hit_add;
  logic [TOT_W-1:0]   total;
  logic               ram_we, ram_wdata, ram_rdata;
  logic [AW-1:0]      ram_waddr, ram_raddr;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && !clr_busy_r;
  assign map_wr_ok = (32'(in_ch.point_x) < MAP_DIM) && (32'(in_ch.point_y) < MAP_DIM);

  assign neg_x  = bx_r < ax_r;
  assign neg_y  = by_r < ay_r;
  assign dabs_x = neg_x ? ax_r - bx_r : bx_r - ax_r;
  assign dabs_y = neg_y ? ay_r - by_r : by_r - ay_r;
  assign prod_x = (COORD_W+REC_W)'(dabs_x) * (COORD_W+REC_W)'(RECIP);
  assign prod_y = (COORD_W+REC_W)'(dabs_y) * (COORD_W+REC_W)'(RECIP);
  assign sq_sum = SQ_W'(sqx_r) + SQ_W'(sqy_r);

  assign sample_more = k_r < K_W'(S);
  assign samp_ok = ({1'b0, cur_x_r} < map_height_r) && ({1'b0, cur_y_r} < map_width_r) &&
                   (32'(cur_x_r) < MAP_DIM) && (32'(cur_y_r) < MAP_DIM);
  assign nx_x = advance(cur_x_r, rem_x_r, step_x_r);
  assign nx_y = advance(cur_y_r, rem_y_r, step_y_r);

  assign sq_shift = {srem_r[RT_W-1:0], rad_r[2*RT_W-1 -: 2]};
  assign sq_trial = (RT_W+3)'(sq_shift) - (RT_W+3)'({root_r, 2'b01});

  assign len_add = LS_W'(len_sum_r) + LS_W'(root_r);
  assign hit_add = (HIT_W+1)'(hit_sum_r) + (HIT_W+1)'(seg_hits_r);
  assign total   = TOT_W'(len_sum_r) +
                   ((TOT_W'(hit_sum_r) * TOT_W'(HIT_WEIGHT)) << FRACTION_BITS);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  assign ram_we    = clr_busy_r || (in_accept && !in_ch.mode && map_wr_ok);
  assign ram_waddr = clr_busy_r ? clr_addr_r :
                     AW'(32'(in_ch.point_x) * 32'(MAP_DIM) + 32'(in_ch.point_y));
  assign ram_wdata = !clr_busy_r && (in_ch.cell_value != '0);
  assign ram_raddr = AW'(32'(cur_x_r) * 32'(MAP_DIM) + 32'(cur_y_r));

  wpc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      seg_cnt_r   <= '0;
      len_sum_r   <= '0;
      hit_sum_r   <= '0;
      ovf_r       <= 1'b0;
      second_r    <= 1'b0;
      last_r      <= 1'b0;
      k_r         <= '0;
      seg_hits_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept && in_ch.mode) begin
            ax_r     <= (seg_cnt_r == '0) ? start_x_r : prev_x_r;
            ay_r     <= (seg_cnt_r == '0) ? start_y_r : prev_y_r;
            bx_r     <= in_ch.point_x;
            by_r     <= in_ch.point_y;
            last_r   <= in_ch.last_waypoint;
            second_r <= 1'b0;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          neg_x_r  <= neg_x;
          neg_y_r  <= neg_y;
          dabs_x_r <= dabs_x;
          dabs_y_r <= dabs_y;
          quo_x_r  <= COORD_W'(prod_x >> REC_SH);
          quo_y_r  <= COORD_W'(prod_y >> REC_SH);
          sqx_r    <= (2*COORD_W)'(dabs_x) * (2*COORD_W)'(dabs_x);
          sqy_r    <= (2*COORD_W)'(dabs_y) * (2*COORD_W)'(dabs_y);
          state_r  <= ST_FIX;
        end
        ST_FIX: begin
          step_x_r   <= split_step(dabs_x_r, quo_x_r, neg_x_r);
          step_y_r   <= split_step(dabs_y_r, quo_y_r, neg_y_r);
          cur_x_r    <= ax_r;
          cur_y_r    <= ay_r;
          rem_x_r    <= '0;
          rem_y_r    <= '0;
          k_r        <= '0;
          seg_hits_r <= '0;
          rd_pend_r  <= 1'b0;
          rad_r      <= (2*RT_W)'(sq_sum) << (2 * FRACTION_BITS);
          root_r     <= '0;
          srem_r     <= '0;
          it_r       <= '0;
          state_r    <= ST_RUN;
        end
        ST_RUN: begin
          if (sample_more) begin
            rd_pend_r <= samp_ok;
            cur_x_r   <= nx_x.cur;
            rem_x_r   <= nx_x.rem;
            cur_y_r   <= nx_y.cur;
            rem_y_r   <= nx_y.rem;
            k_r       <= k_r + 1'b1;
          end else begin
            rd_pend_r <= 1'b0;
          end
          if (rd_pend_r && ram_rdata) begin
            seg_hits_r <= seg_hits_r + 1'b1;
          end
          if (it_r != IT_W'(RT_W)) begin
            rad_r <= rad_r << 2;
            it_r  <= it_r + 1'b1;
            if (!sq_trial[RT_W+2]) begin
              srem_r <= sq_trial[RT_W+1:0];
              root_r <= {root_r[RT_W-2:0], 1'b1};
            end else begin
              srem_r <= sq_shift;
              root_r <= {root_r[RT_W-2:0], 1'b0};
            end
          end
          if (!sample_more && !rd_pend_r && it_r == IT_W'(RT_W)) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          len_sum_r <= (len_add > LS_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_add);
          hit_sum_r <= (hit_add > (HIT_W+1)'(HIT_MAX)) ? HIT_MAX : HIT_W'(hit_add);
          if (!second_r) begin
            ovf_r <= ovf_r || (len_add > LS_W'(LEN_MAX)) ||
                     (hit_add > (HIT_W+1)'(HIT_MAX)) ||
                     (seg_cnt_r >= SEG_W'(MAX_WAYPOINTS));
            if (seg_cnt_r < SEG_W'(MAX_WAYPOINTS)) begin
              seg_cnt_r <= seg_cnt_r + 1'b1;
            end
            prev_x_r <= bx_r;
            prev_y_r <= by_r;
            if (last_r) begin
              ax_r     <= bx_r;
              ay_r     <= by_r;
              bx_r     <= stop_x_r;
              by_r     <= stop_y_r;
              second_r <= 1'b1;
              state_r  <= ST_DIV;
            end else begin
              state_r  <= ST_IDLE;
            end
          end else begin
            ovf_r   <= ovf_r || (len_add > LS_W'(LEN_MAX)) ||
                       (hit_add > (HIT_W+1)'(HIT_MAX));
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_total_r <= (total > TOT_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(total);
            out_len_r   <= len_sum_r;
            out_hits_r  <= hit_sum_r;
            out_ovf_r   <= ovf_r || (total > TOT_W'(TOTAL_MAX));
            len_sum_r   <= '0;
            hit_sum_r   <= '0;
            seg_cnt_r   <= '0;
            ovf_r       <= 1'b0;
            prev_x_r    <= '0;
            prev_y_r    <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.total_cost_q8   = out_total_r;
  assign out_ch.path_length_q8  = out_len_r;
  assign out_ch.blocked_samples = out_hits_r;
  assign out_ch.overflow        = out_ovf_r;

`ifndef SYNTHESIS
  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ch.ready)
    else $error("item taken during grid clear");

  a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= K_W'(S)))
    else $error("sample index past segment end");

  a_hits_le_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (seg_hits_r <= k_r))
    else $error("more hits than samples issued");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("grid write while scoring a segment");

  a_total_ge_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.total_cost_q8 >= TOTAL_W'(out_ch.path_length_q8)))
    else $error("total cost below path length");
`endif

endmodule

>>> bench/waypoint_path_cost_top_test.sv
module waypoint_path_cost_top_test;
  import wpc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MAP_WRITE = 1'b0;
  localparam logic WAYPOINT  = 1'b1;
  localparam int SAMPLES      = SAMPLES_PER_SEGMENT_DEF;
  localparam int SETTLE_CYCLES = 250;
  localparam int STALL_LIMIT   = 300000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 197;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [LEN_W-1:0]   len;
    logic [HIT_W-1:0]   hits;
    logic               ovf;
  } path_cost_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CELL_W-1:0]  digit;
    logic               last;
  } item_t;

  typedef struct packed {
    item_t      item;
    logic       typed;
    path_cost_t want;
  } step_t;

  localparam path_cost_t ZERO_COST = '0;
  localparam path_cost_t COST_10   = '{23'd5120, 21'd5120, 11'd0, 1'b0};

  localparam step_t DIRECTED [22] = '{
    '{'{WAYPOINT,  8'd0,   8'd0,   4'd0,  1'b1}, 1'b1, ZERO_COST},
    '{'{WAYPOINT,  8'd0,   8'd10,  4'd0,  1'b1}, 1'b1, COST_10},
    '{'{MAP_WRITE, 8'd0,   8'd5,   4'd9,  1'b0}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd255, 8'd255, 4'd15, 1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd0,   8'd0,   4'd0,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd0,   8'd10,  4'd0,  1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd199, 8'd199, 4'd1,  1'b0}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd200, 8'd200, 4'd2,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd255, 8'd255, 4'd3,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd199, 8'd199, 4'd4,  1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd0,   8'd5,   4'd0,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd255, 8'd0,   4'd5,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd0,   8'd255, 4'd6,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd170, 8'd85,  4'd7,  1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd85,  8'd170, 4'd8,  1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd85,  8'd170, 4'd10, 1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd1,   8'd1,   4'd11, 1'b0}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd2,   8'd2,   4'd12, 1'b1}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd3,   8'd3,   4'd13, 1'b0}, 1'b0, ZERO_COST},
    '{'{MAP_WRITE, 8'd4,   8'd4,   4'd14, 1'b0}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd4,   8'd4,   4'd15, 1'b1}, 1'b0, ZERO_COST},
    '{'{WAYPOINT,  8'd0,   8'd0,   4'd0,  1'b1}, 1'b1, ZERO_COST}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wpc_cfg_if cfg_ch();
  wpc_in_if  in_ch();
  wpc_out_if out_ch();

  waypoint_path_cost_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scoring state
  bit              occupied [0:MAP_DIM_DEF*MAP_DIM_DEF-1];
  logic [7:0]      start_x, start_y, stop_x, stop_y;
  logic [8:0]      map_w, map_h;
  logic [7:0]      prev_x, prev_y;
  int unsigned     len_sum, hit_sum;
  int              legs;
  bit              path_ovf;

  path_cost_t      pending_costs [$];
  int              mismatches;
  int              stall_cycles;
  bit              src_gaps = 1'b1;
  bit              snk_stalls = 1'b1;
  int              win_x, win_y;

  function automatic void set_reg(input cfg_idx_t idx, input logic [8:0] d);
    case (idx)
      CFG_START_X:    start_x = d[7:0];
      CFG_START_Y:    start_y = d[7:0];
      CFG_STOP_X:     stop_x  = d[7:0];
      CFG_STOP_Y:     stop_y  = d[7:0];
      CFG_MAP_WIDTH:  map_w   = d;
      CFG_MAP_HEIGHT: map_h   = d;
      default: ;
    endcase
  endfunction

  function automatic int unsigned root_floor(input longint unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int i = 17; i >= 0; i--) begin
      t = r | (32'd1 << i);
      if (longint'(t) * longint'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic void score_leg(input logic [7:0] ax, input logic [7:0] ay,
                                    input logic [7:0] bx, input logic [7:0] by);
    int unsigned dx, dy, leg, hits, row, col;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    leg = root_floor(longint'(dx * dx + dy * dy) << (2 * FRACTION_BITS_DEF));
    if (longint'(len_sum) + leg > LEN_MAX) begin
      len_sum  = LEN_MAX;
      path_ovf = 1'b1;
    end else begin
      len_sum += leg;
    end
    hits = 0;
    for (int k = 0; k < SAMPLES; k++) begin
      row = (ax * (SAMPLES - k) + bx * k) / SAMPLES;
      col = (ay * (SAMPLES - k) + by * k) / SAMPLES;
      if (row < map_h && col < map_w && row < MAP_DIM_DEF && col < MAP_DIM_DEF)
        if (occupied[row * MAP_DIM_DEF + col]) hits++;
    end
    if (hit_sum + hits > HIT_MAX) begin
      hit_sum  = HIT_MAX;
      path_ovf = 1'b1;
    end else begin
      hit_sum += hits;
    end
  endfunction

  function automatic bit score_item(input item_t it, output path_cost_t cost);
    longint unsigned total;
    cost = '0;
    if (it.mode == MAP_WRITE) begin
      occupied[{it.x, it.y}] = (it.digit != 0);
      return 1'b0;
    end
    if (legs == 0) score_leg(start_x, start_y, it.x, it.y);
    else score_leg(prev_x, prev_y, it.x, it.y);
    if (legs >= MAX_WAYPOINTS_DEF) path_ovf = 1'b1;
    else legs++;
    prev_x = it.x;
    prev_y = it.y;
    if (!it.last) return 1'b0;
    score_leg(it.x, it.y, stop_x, stop_y);
    total = longint'(len_sum) + ((longint'(hit_sum) * HIT_WEIGHT) << FRACTION_BITS_DEF);
    if (total > TOTAL_MAX) begin
      total    = TOTAL_MAX;
      path_ovf = 1'b1;
    end
    cost.total = total[TOTAL_W-1:0];
    cost.len   = len_sum[LEN_W-1:0];
    cost.hits  = hit_sum[HIT_W-1:0];
    cost.ovf   = path_ovf;
    len_sum  = 0;
    hit_sum  = 0;
    legs     = 0;
    path_ovf = 1'b0;
    prev_x   = '0;
    prev_y   = '0;
    return 1'b1;
  endfunction

  task automatic send_item(input item_t it, input bit typed, input path_cost_t want);
    path_cost_t cost;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= it.mode;
    in_ch.point_x       <= it.x;
    in_ch.point_y       <= it.y;
    in_ch.cell_value    <= it.digit;
    in_ch.last_waypoint <= it.last;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    if (score_item(it, cost)) pending_costs.push_back(typed ? want : cost);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [8:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    set_reg(idx, d);
  endtask

  task automatic set_config(input logic [8:0] sx, input logic [8:0] sy,
                            input logic [8:0] tx, input logic [8:0] ty,
                            input logic [8:0] w, input logic [8:0] h);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_STOP_X, tx);
    write_reg(CFG_STOP_Y, ty);
    write_reg(CFG_MAP_WIDTH, w);
    write_reg(CFG_MAP_HEIGHT, h);
    cfg_ch.valid <= 1'b0;
  endtask

  // drain results, then allow for a waypoint still being scored
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_coord(input int base, input int spread);
    if ($urandom_range(0, 99) < spread) return 8'($urandom_range(0, 255));
    return 8'(base + $urandom_range(0, 31));
  endfunction

  function automatic item_t map_item();
    item_t it;
    it.mode  = MAP_WRITE;
    it.x     = pick_coord(win_x, 10);
    it.y     = pick_coord(win_y, 10);
    it.digit = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 15)) : 4'd0;
    it.last  = 1'($urandom);
    return it;
  endfunction

  function automatic item_t waypoint(input logic last);
    item_t it;
    it.mode  = WAYPOINT;
    it.x     = pick_coord(win_x, 20);
    it.y     = pick_coord(win_y, 20);
    it.digit = 4'($urandom);
    it.last  = last;
    return it;
  endfunction

  function automatic int path_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 6);
    if (r < 97) return $urandom_range(7, 16);
    return $urandom_range(17, 24);
  endfunction

  function automatic logic [8:0] rand_dim();
    if ($urandom_range(0, 3) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(24, 256));
  endfunction

  task automatic run_phase(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) < 3) begin
        len = $urandom_range(1, 6);
        repeat (len) send_item(map_item(), 1'b0, ZERO_COST);
        sent += len;
      end else begin
        len = path_len();
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(map_item(), 1'b0, ZERO_COST);
            sent++;
          end
          send_item(waypoint(i == len - 1), 1'b0, ZERO_COST);
          sent++;
        end
      end
    end
    // sometimes leave a path open across the register change
    if ($urandom_range(0, 1) == 1) send_item(waypoint(1'b0), 1'b0, ZERO_COST);
  endtask

  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (snk_stalls && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(negedge clk) begin
    path_cost_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_costs.size() == 0) begin
        $display("%0t unexpected result: expected none actual total %0d",
                 $time, out_ch.total_cost_q8);
        mismatches++;
      end else begin
        want = pending_costs.pop_front();
        if (out_ch.total_cost_q8 !== want.total)
          report("total_cost_q8", want.total, out_ch.total_cost_q8);
        if (out_ch.path_length_q8 !== want.len)
          report("path_length_q8", want.len, out_ch.path_length_q8);
        if (out_ch.blocked_samples !== want.hits)
          report("blocked_samples", want.hits, out_ch.blocked_samples);
        if (out_ch.overflow !== want.ovf)
          report("overflow", want.ovf, out_ch.overflow);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no item moved for %0d cycles", $time, stall_cycles);
      $display("FAIL waypoint_path_cost_top");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    stall_cycles = 0;
    len_sum  = 0;
    hit_sum  = 0;
    legs     = 0;
    path_ovf = 1'b0;
    prev_x   = '0;
    prev_y   = '0;
    start_x  = '0;
    start_y  = '0;
    stop_x   = '0;
    stop_y   = '0;
    map_w    = DIM_RESET;
    map_h    = DIM_RESET;
    win_x    = 0;
    win_y    = 0;
    in_ch.valid         <= 1'b0;
    in_ch.mode          <= MAP_WRITE;
    in_ch.point_x       <= '0;
    in_ch.point_y       <= '0;
    in_ch.cell_value    <= '0;
    in_ch.last_waypoint <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_START_X;
    cfg_ch.data         <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
    settle();

    // hit count saturates: every sample lands on one occupied entry
    set_config(9'd9, 9'd9, 9'd9, 9'd9, 9'd256, 9'd256);
    send_item('{MAP_WRITE, 8'd9, 8'd9, 4'd1, 1'b0}, 1'b0, ZERO_COST);
    for (int i = 0; i < 22; i++)
      send_item('{WAYPOINT, 8'd9, 8'd9, 4'd0, 1'(i == 21)}, 1'b0, ZERO_COST);
    // length saturates: corner to corner
    for (int i = 0; i < 24; i++)
      send_item('{WAYPOINT, {8{i[0]}}, {8{i[0]}}, 4'd0, 1'(i == 23)}, 1'b0, ZERO_COST);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: set_config(9'd0, 9'd0, 9'd255, 9'd255, 9'd256, 9'd256);
        1: set_config(9'd255, 9'd255, 9'd0, 9'd0, 9'd0, 9'd0);
        2: set_config(9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                      9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)), 9'd1, 9'd1);
        3: set_config(9'($urandom_range(256, 511)), 9'($urandom_range(256, 511)),
                      9'($urandom_range(256, 511)), 9'($urandom_range(256, 511)),
                      9'd511, 9'd511);
        default: set_config(9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                            9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                            rand_dim(), rand_dim());
      endcase
      src_gaps   = (ph != 4) && (ph != PHASES - 1);
      snk_stalls = src_gaps;
      win_x = (ph == 2) ? 0 : $urandom_range(0, 224);
      win_y = (ph == 2) ? 0 : $urandom_range(0, 224);
      run_phase(PHASE_ITEMS);
    end
    settle();

    if (mismatches == 0)
      $display("PASS waypoint_path_cost_top");
    else
      $display("FAIL waypoint_path_cost_top");
    $finish;
  end

endmodule
